// File: rtl/b58e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b58e_pkg;

  localparam int MAX_BYTES    = 34;
  localparam int MAX_DIGITS   = 47;
  localparam int RESULT_LIMIT = 47;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int ZPC_W = $clog2(MAX_BYTES + 1);
  localparam int TOT_W = ((CNT_W > ZPC_W) ? CNT_W : ZPC_W) + 1;

  localparam int RADIX       = 58;
  localparam int RECIP58     = 1130;  // ceil(2^16 / 58), exact for v < 2^14
  localparam int RECIP_SHIFT = 16;

  localparam logic [8*RADIX-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b58e_byte_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
    logic       overflow;
  } b58e_char_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } b58e_cell_ctl_t;

  typedef struct packed {
    logic [7:0] q;
    logic [5:0] r;
  } b58e_dm_t;

  // digit*256 + carry never exceeds 14847, so the reciprocal needs no correction
  function automatic b58e_dm_t b58e_divmod(input logic [13:0] v);
    logic [24:0] p;
    logic [13:0] qm;
    b58e_dm_t    res;
    p     = 25'(v) * 25'(RECIP58);
    res.q = p[RECIP_SHIFT+7:RECIP_SHIFT];
    qm    = {6'd0, res.q} * 14'(RADIX);
    res.r = 6'(v - qm);
    return res;
  endfunction

  function automatic logic [6:0] b58e_char(input logic [5:0] d);
    logic [5:0] i;
    i = (d > 6'(RADIX - 1)) ? 6'd0 : d;
    return ALPHABET[8*(RADIX - 1 - int'(i)) +: 7];
  endfunction

endpackage

`default_nettype wire

// File: rtl/base58_byte_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | valid       | stall       | item
// ----------+-------------+-------------+---------------------------------
// byte in   | byte_valid  | byte_stall  | byte_item (data_byte, last_byte)
// char out  | char_valid  | char_stall  | char_item (out_char, last_char, overflow)
//
// Bytes are taken one per cycle until the last one; each carry wave walks the
// digit cells, one cell a cycle, from least significant upward.
// After the last byte the carry waves drain, leading zero digits are skipped, then
// one character a cycle while char_stall is low.
// byte_stall is high from the last byte until the final character is loaded.
// rst is synchronous; it clears all digit cells and counters.

module base58_byte_encoder_top import b58e_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire b58e_byte_t byte_item,
  output logic            char_valid,
  input  wire logic       char_stall,
  output b58e_char_t      char_item
);

  typedef enum logic [1:0] {IDLE, DRAIN, SKIP, EMIT} state_t;

  state_t            state;
  logic [ZPC_W-1:0]  byte_count;
  logic [ZPC_W-1:0]  zero_prefix_count;
  logic              seen_nonzero;
  logic              overflow_seen;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  n_out;

  logic [5:0]        cell_digit [MAX_DIGITS];
  logic [7:0]        cell_cout  [MAX_DIGITS];
  logic              cell_coutv [MAX_DIGITS];
  b58e_cell_ctl_t    cell_ctl;

  logic              byte_acc;
  logic              absorb_v;
  logic              skip_go;
  logic              emit_go;
  logic              emit_last;
  logic              emit_prefix;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  n_next;

  assign byte_stall  = (state != IDLE);
  assign byte_acc    = byte_valid && !byte_stall;
  assign absorb_v    = byte_acc && (byte_count < ZPC_W'(MAX_BYTES));

  assign skip_go     = (state == SKIP) && (cell_digit[0] == 6'd0) && (rem != '0);
  assign emit_go     = (state == EMIT) && (!char_valid || !char_stall);
  assign emit_last   = (TOT_W'(cnt) + TOT_W'(1)) == TOT_W'(n_out);
  assign emit_prefix = TOT_W'(cnt) < TOT_W'(zero_prefix_count);

  assign total  = TOT_W'(zero_prefix_count) + TOT_W'(rem);
  // nothing to show still gives a single '1'
  assign n_next = (total == '0) ? CNT_W'(1) :
                  (total > TOT_W'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) :
                  CNT_W'(total);

  assign cell_ctl.shift = skip_go || (emit_go && !emit_prefix);
  assign cell_ctl.clr   = emit_go && emit_last;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    if (k == MAX_DIGITS - 1) begin : g_lsd
      b58e_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (cell_ctl),
        .cin      (byte_item.data_byte),
        .cin_v    (absorb_v),
        .shift_in (6'd0),
        .digit    (cell_digit[k]),
        .cout     (cell_cout[k]),
        .cout_v   (cell_coutv[k])
      );
    end else begin : g_mid
      b58e_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (cell_ctl),
        .cin      (cell_cout[k+1]),
        .cin_v    (cell_coutv[k+1]),
        .shift_in (cell_digit[k+1]),
        .digit    (cell_digit[k]),
        .cout     (cell_cout[k]),
        .cout_v   (cell_coutv[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      byte_count        <= '0;
      zero_prefix_count <= '0;
      seen_nonzero      <= 1'b0;
      overflow_seen     <= 1'b0;
      cnt               <= '0;
      rem               <= '0;
      n_out             <= '0;
      char_valid        <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        char_valid <= 1'b0;
      end
      // carry leaving the top digit is lost
      if (cell_coutv[0] && (cell_cout[0] != 8'd0)) begin
        overflow_seen <= 1'b1;
      end

      unique case (state)
        IDLE: begin
          if (byte_acc) begin
            if (absorb_v) begin
              byte_count <= byte_count + ZPC_W'(1);
              if (!seen_nonzero && (byte_item.data_byte == 8'd0)) begin
                zero_prefix_count <= zero_prefix_count + ZPC_W'(1);
              end
              if (byte_item.data_byte != 8'd0) begin
                seen_nonzero <= 1'b1;
              end
            end else begin
              overflow_seen <= 1'b1;
            end
            if (byte_item.last_byte) begin
              state <= DRAIN;
              cnt   <= '0;
            end
          end
        end
        DRAIN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_DIGITS - 1)) begin
            state <= SKIP;
            rem   <= CNT_W'(MAX_DIGITS);
          end
        end
        SKIP: begin
          if (skip_go) begin
            rem <= rem - CNT_W'(1);
          end else begin
            n_out <= n_next;
            cnt   <= '0;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (emit_go) begin
            char_valid          <= 1'b1;
            char_item.out_char  <= b58e_char(emit_prefix ? 6'd0 : cell_digit[0]);
            char_item.last_char <= emit_last;
            char_item.overflow  <= overflow_seen;
            cnt                 <= cnt + CNT_W'(1);
            if (emit_last) begin
              state             <= IDLE;
              byte_count        <= '0;
              zero_prefix_count <= '0;
              seen_nonzero      <= 1'b0;
              overflow_seen     <= 1'b0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_wave_drained: assert property (@(posedge clk) disable iff (rst)
    (state == SKIP || state == EMIT) |-> !cell_coutv[0])
    else $error("carry wave still in the digit chain after drain");

  a_msg_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> (byte_count != '0))
    else $error("encoding started with no byte counted");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_last) |=> (state == IDLE && cell_digit[0] == 6'd0 &&
                                char_valid && char_item.last_char))
    else $error("final character did not clear the digit chain");

endmodule

`default_nettype wire

// File: rtl/b58e_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module b58e_cell import b58e_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b58e_cell_ctl_t ctl,
  input  wire logic [7:0]     cin,
  input  wire logic           cin_v,
  input  wire logic [5:0]     shift_in,
  output logic [5:0]          digit,
  output logic [7:0]          cout,
  output logic                cout_v
);

  b58e_dm_t dm;

  assign dm = b58e_divmod({digit, 8'd0} + {6'd0, cin});

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      digit  <= '0;
      cout_v <= 1'b0;
    end else begin
      if (ctl.shift) begin
        digit <= shift_in;
      end else if (cin_v) begin
        digit <= dm.r;
      end
      cout_v <= cin_v;
    end
    cout <= dm.q;
  end

endmodule

`default_nettype wire

// File: sim/tb_base58_byte_encoder_top.sv
`timescale 1ns / 1ps

module tb_base58_byte_encoder_top;
  import b58e_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 250;
  localparam int END_WAIT       = 2 * MAX_DIGITS + 16;
  localparam int MAX_PRINTED    = 30;

  // Encoding predictor plus the queue of characters still owed by the block.
  class b58_scoreboard;
    logic [5:0]  digits [MAX_DIGITS];
    int unsigned lead_zeros;
    int unsigned absorbed;
    bit          seen_nonzero;
    bit          ovf;
    b58e_char_t  char_q [$];
    string       alphabet;
    int unsigned errors;
    int unsigned checked;
    int unsigned messages;
    int unsigned ovf_messages;

    function new();
      alphabet     = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      errors       = 0;
      checked      = 0;
      messages     = 0;
      ovf_messages = 0;
      restart();
    endfunction

    function void restart();
      int i;
      for (i = 0; i < MAX_DIGITS; i++) digits[i] = '0;
      lead_zeros   = 0;
      absorbed     = 0;
      seen_nonzero = 1'b0;
      ovf          = 1'b0;
    endfunction

    function void note_byte(b58e_byte_t b);
      int unsigned carry, v, first, total, n, k, idx, lim;
      int          j;
      logic [5:0]  d;
      logic [7:0]  ch;
      b58e_char_t  c;
      if (absorbed < MAX_BYTES) begin
        absorbed++;
        if (!seen_nonzero && b.data_byte == 8'd0) lead_zeros++;
        if (b.data_byte != 8'd0) seen_nonzero = 1'b1;
        // multiply the digit register by 256 and add the byte, lsd first
        carry = 32'(b.data_byte);
        for (j = MAX_DIGITS - 1; j >= 0; j--) begin
          v         = 256 * digits[j] + carry;
          digits[j] = 6'(v % 58);
          carry     = v / 58;
        end
        if (carry != 0) ovf = 1'b1;
      end else begin
        ovf = 1'b1;
      end
      if (!b.last_byte) return;

      first = 0;
      while (first < MAX_DIGITS && digits[first] == 6'd0) first++;
      total = lead_zeros + (MAX_DIGITS - first);
      lim   = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
      // a zero value with no counted zero byte still gives a single '1'
      n     = (total == 0) ? 1 : ((total < lim) ? total : lim);
      for (k = 0; k < n; k++) begin
        if (k < lead_zeros) begin
          d = 6'd0;
        end else begin
          idx = first + k - lead_zeros;
          d   = (idx < MAX_DIGITS) ? digits[idx] : 6'd0;
        end
        if (d > 6'd57) d = 6'd0;
        ch          = alphabet[d];
        c.out_char  = ch[6:0];
        c.last_char = (k + 1 == n);
        c.overflow  = ovf;
        char_q.push_back(c);
      end
      messages++;
      if (ovf) ovf_messages++;
      restart();
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_char(input b58e_char_t got);
      b58e_char_t want;
      if (char_q.size() == 0) begin
        report($sformatf("char 0x%02h arrived with nothing pending", got.out_char));
        return;
      end
      want = char_q.pop_front();
      checked++;
      if (got.out_char !== want.out_char || got.last_char !== want.last_char ||
          got.overflow !== want.overflow)
        report($sformatf("got char 0x%02h last %0b ovf %0b, wanted 0x%02h last %0b ovf %0b",
                         got.out_char, got.last_char, got.overflow,
                         want.out_char, want.last_char, want.overflow));
    endtask

    task check_drained();
      if (char_q.size() != 0)
        report($sformatf("%0d characters never arrived", char_q.size()));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       byte_valid = 1'b0;
  b58e_byte_t byte_item  = '0;
  logic       char_stall = 1'b0;
  logic       byte_stall;
  logic       char_valid;
  b58e_char_t char_item;

  b58_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  base58_byte_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  always #4 clk = ~clk;

  // all inputs change by nonblocking assignment, so edge sampling sees settled values
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) sb.note_byte(byte_item);
    if (!rst && char_valid && !char_stall) sb.check_char(char_item);
  end

  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
      hold_left  <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= LONG_HOLD;
      char_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      char_stall <= 1'b1;
    end else begin
      char_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input b58e_byte_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    items_sent++;
  endtask

  // fill < 0 gives random bytes after the leading zeros
  task automatic send_msg(input int len, input int lead, input int fill);
    b58e_byte_t it;
    int         i;
    for (i = 0; i < len; i++) begin
      if (i < lead)      it.data_byte = 8'd0;
      else if (fill < 0) it.data_byte = 8'($urandom_range(255));
      else               it.data_byte = 8'(fill);
      it.last_byte = (i == len - 1);
      send_byte(it);
    end
  endtask

  initial begin
    int phase, start, kind, len, lead;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_msg(1, 1, 0);     // lone zero byte
    send_msg(1, 0, 255);
    send_msg(1, 0, 1);
    send_msg(1, 0, 57);    // top digit value
    send_msg(1, 0, 58);    // first two-digit value
    send_msg(3, 2, 1);     // leading zeros then a small value
    send_msg(3, 1, 0);     // all zeros
    send_msg(2, 1, 255);
    send_msg(4, 0, 128);
    send_msg(2, 0, -1);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 8 : 0;
      start = items_sent;
      if (phase == 0) begin
        send_msg(MAX_BYTES, 0, 255);      // longest message, largest value
        send_msg(MAX_BYTES + 2, 0, -1);   // bytes past the limit are dropped
      end
      // receiver holds off long enough for the input side to back up
      if (phase == 2) hold_asked++;
      while (items_sent - start < RANDOM_ITEMS / 3) begin
        kind = $urandom_range(9);
        case (kind)
          0: begin
            send_msg(MAX_BYTES, 0, ($urandom_range(3) == 0) ? 255 : -1);
          end
          1: begin
            len  = $urandom_range(MAX_BYTES + 6, MAX_BYTES + 1);
            lead = ($urandom_range(3) == 0) ? len : $urandom_range(2);
            send_msg(len, lead, -1);
          end
          2: begin
            send_msg($urandom_range(6, 1), 0, 0);
          end
          3: begin
            lead = $urandom_range(4, 1);
            send_msg(lead + $urandom_range(5, 1), lead, -1);
          end
          default: begin
            send_msg($urandom_range(8, 1), 0, -1);
          end
        endcase
      end
    end
    byte_valid <= 1'b0;
    // let the monitor note the final byte before looking at the queue
    @(posedge clk);

    while (sb.char_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Run covered %0d bytes in %0d messages (%0d with overflow), %0d characters checked",
             items_sent, sb.messages, sb.ovf_messages, sb.checked);
    $display("Stall mixes: light/heavy, heavy/light, none, plus one long output hold");
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
